// ----- hdl/ckbs_pkg.sv -----
// ckbs_pkg: shared types, widths and codes for the composite key table search core
// no dependencies; imported by the interfaces, the table ram user and the top level
`default_nettype none

package ckbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 16;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int LEN_W   = IDX_W + 1;
    localparam int VAL_W   = 16;
    localparam int FIELD_W = 8;
    localparam int KC_W    = 2;
    localparam int ENTRY_W = 3 * KEY_WIDTH + VAL_W;
    localparam int QKEY_W  = 3 * KEY_WIDTH;

    // apb register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_KEY_COUNT    = 2'd0;
    localparam logic [1:0] REG_TABLE_LENGTH = 2'd1;
    localparam logic [1:0] REG_MISS_VALUE   = 2'd2;

    // request commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/ckbs_if.sv -----
// ckbs_req_if / ckbs_rsp_if: valid-ready channels for requests and lookup results
// depends on ckbs_pkg for field widths
`default_nettype none

interface ckbs_req_if;
    import ckbs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [FIELD_W-1:0]   entry_index;
    logic [KEY_WIDTH-1:0] key_a;
    logic [KEY_WIDTH-1:0] key_b;
    logic [KEY_WIDTH-1:0] key_c;
    logic [VAL_W-1:0]     entry_value;

    modport source (
        output valid, cmd, entry_index, key_a, key_b, key_c, entry_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, key_a, key_b, key_c, entry_value,
        output ready
    );
endinterface

interface ckbs_rsp_if;
    import ckbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [VAL_W-1:0]   result_value;
    logic [FIELD_W-1:0] match_index;

    modport source (
        output valid, found, result_value, match_index,
        input  ready
    );
    modport sink (
        input  valid, found, result_value, match_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/composite_key_table_binary_search_core.sv -----
// Sorted table lookup with up to three 16-bit keys per entry. Write requests store
// {key_a, key_b, key_c, entry_value} at entry_index and give no result. A lookup
// request runs a binary search over entries 0 .. table_length-1 (length saturated
// to 256), comparing key_count keys lexicographically, key_a first (a key_count of
// zero compares one key). Each probe is one read of the single-port table ram. A
// lookup is accepted, probes the table (ceil(log2(length+1)) probes at most, nine
// for a full table) and then moves its answer into the output register once that
// register is free, after which the next request is taken. A finished lookup waits
// in its done state for as long as the previous result is held in the output register.
// The output register lets a new request in while the previous result still waits.
// The table has no reset; searching unwritten entries gives undefined results.
// Software keeps the searched entries sorted.
// depends on ckbs_pkg, ckbs_if (ckbs_req_if, ckbs_rsp_if) and ckbs_ram
`default_nettype none

module composite_key_table_binary_search_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    ckbs_req_if.sink                     i_req,
    ckbs_rsp_if.source                   o_rsp,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ckbs_pkg::APB_AW-1:0] paddr,
    input  wire logic [ckbs_pkg::APB_DW-1:0] pwdata,
    output logic      [ckbs_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import ckbs_pkg::*;

    // configuration registers
    logic [KC_W-1:0]  r_key_count;
    logic [LEN_W-1:0] r_table_length;
    logic [VAL_W-1:0] r_miss_value;

    // search state
    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_lo, n_lo;
    logic [LEN_W-1:0]    r_hi, n_hi;
    logic [IDX_W-1:0]    r_mid, n_mid;
    logic [QKEY_W-1:0]   r_query, n_query;
    logic                r_res_found, n_res_found;
    logic [VAL_W-1:0]    r_res_value, n_res_value;
    logic [FIELD_W-1:0]  r_res_index, n_res_index;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_found;
    logic [VAL_W-1:0]    r_out_value;
    logic [FIELD_W-1:0]  r_out_index;

    // ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               req_fire;
    logic               cfg_wr;
    logic               slot_free;
    logic [LEN_W-1:0]   len_sat;
    logic [QKEY_W-1:0]  key_mask;
    logic [QKEY_W-1:0]  ent_keys;
    logic [QKEY_W-1:0]  qry_keys;
    logic               ent_lt;
    logic               ent_eq;
    logic [LEN_W-1:0]   s_lo;
    logic [LEN_W-1:0]   s_hi;
    logic [LEN_W:0]     s_sum;
    logic [IDX_W-1:0]   s_mid;
    logic               s_live;

    assign req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || o_rsp.ready;

    // ---------------- apb ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count    <= KC_W'(1);
            r_table_length <= '0;
            r_miss_value   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_KEY_COUNT:    r_key_count    <= pwdata[KC_W-1:0];
                REG_TABLE_LENGTH: r_table_length <= pwdata[LEN_W-1:0];
                REG_MISS_VALUE:   r_miss_value   <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_KEY_COUNT:    prdata = APB_DW'(r_key_count);
            REG_TABLE_LENGTH: prdata = APB_DW'(r_table_length);
            REG_MISS_VALUE:   prdata = APB_DW'(r_miss_value);
            default:          prdata = '0;
        endcase
    end

    // ---------------- table ----------------
    ckbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------- compare ----------------
    assign len_sat = (r_table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                            : r_table_length;

    // unused keys are zeroed on both sides so one wide compare is lexicographic
    assign key_mask = { {KEY_WIDTH{1'b1}},
                        {KEY_WIDTH{r_key_count[1]}},
                        {KEY_WIDTH{r_key_count == KC_W'(3)}} };
    assign ent_keys = ram_rdata[ENTRY_W-1:VAL_W] & key_mask;
    assign qry_keys = r_query & key_mask;
    assign ent_lt   = ent_keys < qry_keys;
    assign ent_eq   = ent_keys == qry_keys;

    // live range is [lo, hi); floor midpoint of lo .. hi-1
    always_comb begin
        if (r_state == ST_PROBE) begin
            s_lo = ent_lt ? LEN_W'(r_mid) + LEN_W'(1) : r_lo;
            s_hi = ent_lt ? r_hi : LEN_W'(r_mid);
        end else begin
            s_lo = '0;
            s_hi = len_sat;
        end
    end

    assign s_live = s_lo < s_hi;
    assign s_sum  = (LEN_W+1)'(s_lo) + (LEN_W+1)'(s_hi) - (LEN_W+1)'(1);
    assign s_mid  = s_sum[IDX_W:1];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire && i_req.cmd == CMD_LOOKUP) begin
                    n_state = s_live ? ST_PROBE : ST_DONE;
                end
            end
            ST_PROBE: begin
                if (ent_eq || !s_live) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        ram_we      = 1'b0;
        ram_addr    = s_mid;
        ram_wdata   = {i_req.key_a, i_req.key_b, i_req.key_c, i_req.entry_value};
        n_lo        = s_lo;
        n_hi        = s_hi;
        n_mid       = s_mid;
        n_query     = r_query;
        n_res_found = r_res_found;
        n_res_value = r_res_value;
        n_res_index = r_res_index;
        n_out_valid = r_out_valid && !o_rsp.ready;
        case (r_state)
            ST_IDLE: begin
                if (req_fire && i_req.cmd == CMD_WRITE) begin
                    ram_we   = 1'b1;
                    ram_addr = i_req.entry_index[IDX_W-1:0];
                end
                if (req_fire && i_req.cmd == CMD_LOOKUP) begin
                    n_query     = {i_req.key_a, i_req.key_b, i_req.key_c};
                    n_res_found = 1'b0;
                    n_res_value = r_miss_value;
                    n_res_index = '0;
                end
            end
            ST_PROBE: begin
                if (ent_eq) begin
                    n_res_found = 1'b1;
                    n_res_value = ram_rdata[VAL_W-1:0];
                    n_res_index = FIELD_W'(r_mid);
                end else if (!s_live) begin
                    n_res_found = 1'b0;
                    n_res_value = r_miss_value;
                    n_res_index = '0;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_query     <= n_query;
        r_res_found <= n_res_found;
        r_res_value <= n_res_value;
        r_res_index <= n_res_index;
        if (r_state == ST_DONE && slot_free) begin
            r_out_found <= r_res_found;
            r_out_value <= r_res_value;
            r_out_index <= r_res_index;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.match_index  = r_out_index;

endmodule

`default_nettype wire

// ----- hdl/ckbs_ram.sv -----
// ckbs_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module ckbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sim/composite_key_table_binary_search_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for composite_key_table_binary_search_core: table loads, lookups
// predicted by an in-bench binary search, apb register writes with readback
// depends on ckbs_pkg, ckbs_req_if / ckbs_rsp_if and the core rtl

module composite_key_table_binary_search_core_tb;
    import ckbs_pkg::*;

    localparam int ITEM_TARGET  = 530;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PERCENT = 19;
    localparam int LONG_STALL   = 300;

    typedef struct packed {
        logic                 cmd;
        logic [FIELD_W-1:0]   entry_index;
        logic [KEY_WIDTH-1:0] key_a;
        logic [KEY_WIDTH-1:0] key_b;
        logic [KEY_WIDTH-1:0] key_c;
        logic [VAL_W-1:0]     entry_value;
    } t_request;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key_a;
        logic [KEY_WIDTH-1:0] key_b;
        logic [KEY_WIDTH-1:0] key_c;
        logic [VAL_W-1:0]     value;
    } t_table_entry;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   result_value;
        logic [FIELD_W-1:0] match_index;
    } t_lookup_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ckbs_req_if req_ch ();
    ckbs_rsp_if rsp_ch ();

    composite_key_table_binary_search_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench copy of the table and the registers
    t_table_entry     table_model [TABLE_DEPTH];
    logic [KC_W-1:0]  key_count_cfg    = 2'd1;
    logic [LEN_W-1:0] table_length_cfg = '0;
    logic [VAL_W-1:0] miss_value_cfg   = '0;

    t_lookup_result pending_lookups [$];
    int             error_count = 0;
    int             items_sent  = 0;
    bit             no_idle     = 1'b0;
    int             stall_request = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int searched_length();
        return (table_length_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_length_cfg);
    endfunction

    function automatic int compared_keys();
        return (key_count_cfg == 0) ? 1 : int'(key_count_cfg);
    endfunction

    // lexicographic order over the compared keys is plain order of the top bits
    function automatic logic [QKEY_W-1:0] key_prefix(logic [QKEY_W-1:0] keys);
        return keys >> (KEY_WIDTH * (3 - compared_keys()));
    endfunction

    function automatic t_lookup_result search_table(t_request r);
        t_lookup_result res;
        logic [QKEY_W-1:0] want;
        logic [QKEY_W-1:0] probe;
        int lo;
        int hi;
        int mid;
        res.found        = 1'b0;
        res.result_value = miss_value_cfg;
        res.match_index  = '0;
        want = key_prefix({r.key_a, r.key_b, r.key_c});
        lo   = 0;
        hi   = searched_length() - 1;
        while (lo <= hi) begin
            mid   = (lo + hi) / 2;
            probe = key_prefix({table_model[mid].key_a, table_model[mid].key_b,
                                table_model[mid].key_c});
            if (probe < want) begin
                lo = mid + 1;
            end else if (probe > want) begin
                hi = mid - 1;
            end else begin
                res.found        = 1'b1;
                res.result_value = table_model[mid].value;
                res.match_index  = mid[FIELD_W-1:0];
                return res;
            end
        end
        return res;
    endfunction

    task automatic send_request(t_request r);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= r.cmd;
        req_ch.entry_index <= r.entry_index;
        req_ch.key_a       <= r.key_a;
        req_ch.key_b       <= r.key_b;
        req_ch.key_c       <= r.key_c;
        req_ch.entry_value <= r.entry_value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (r.cmd == CMD_WRITE) begin
            table_model[r.entry_index] = {r.key_a, r.key_b, r.key_c, r.entry_value};
        end else begin
            pending_lookups.push_back(search_table(r));
        end
        items_sent++;
    endtask

    task automatic send_write(logic [FIELD_W-1:0] idx, logic [KEY_WIDTH-1:0] ka, kb, kc,
                              logic [VAL_W-1:0] val);
        t_request r;
        r.cmd         = CMD_WRITE;
        r.entry_index = idx;
        r.key_a       = ka;
        r.key_b       = kb;
        r.key_c       = kc;
        r.entry_value = val;
        send_request(r);
    endtask

    task automatic send_lookup(logic [KEY_WIDTH-1:0] ka, kb, kc);
        t_request r;
        r.cmd         = CMD_LOOKUP;
        r.entry_index = FIELD_W'($urandom);
        r.key_a       = ka;
        r.key_b       = kb;
        r.key_c       = kc;
        r.entry_value = VAL_W'($urandom);
        send_request(r);
    endtask

    // mostly keys of a live entry, some one off from one, the rest anything
    task automatic send_random_lookup();
        t_table_entry ent;
        logic [QKEY_W-1:0] keys;
        logic [QKEY_W-1:0] mask;
        logic [QKEY_W-1:0] step;
        int len;
        int sel;
        len  = searched_length();
        sel  = $urandom_range(99);
        keys = {KEY_WIDTH'($urandom), KEY_WIDTH'($urandom), KEY_WIDTH'($urandom)};
        if (len != 0 && sel < 70) begin
            ent  = table_model[$urandom_range(len - 1)];
            mask = {QKEY_W{1'b1}} << (KEY_WIDTH * (3 - compared_keys()));
            keys = ({ent.key_a, ent.key_b, ent.key_c} & mask) | (keys & ~mask);
            if (sel >= 55) begin
                step = QKEY_W'(1) << (KEY_WIDTH * (3 - compared_keys()));
                keys = ($urandom_range(1) != 0) ? keys + step : keys - step;
            end
        end
        send_lookup(keys[3*KEY_WIDTH-1:2*KEY_WIDTH], keys[2*KEY_WIDTH-1:KEY_WIDTH],
                    keys[KEY_WIDTH-1:0]);
    endtask

    // rewrites entries 0 .. count-1, in key order unless asked otherwise
    task automatic load_table(int count, bit in_order);
        logic [QKEY_W-1:0] keys;
        logic [QKEY_W-1:0] step;
        keys = {KEY_WIDTH'($urandom_range(16'hF000)), KEY_WIDTH'($urandom),
                KEY_WIDTH'($urandom)};
        for (int i = 0; i < count; i++) begin
            if (in_order) begin
                // a zero step leaves duplicate keys
                step = QKEY_W'($urandom_range(3));
                keys = keys + (step << (KEY_WIDTH * $urandom_range(2)));
            end else begin
                keys = {KEY_WIDTH'($urandom), KEY_WIDTH'($urandom), KEY_WIDTH'($urandom)};
            end
            send_write(FIELD_W'(i), keys[3*KEY_WIDTH-1:2*KEY_WIDTH],
                       keys[2*KEY_WIDTH-1:KEY_WIDTH], keys[KEY_WIDTH-1:0], VAL_W'($urandom));
        end
    endtask

    // stop offering requests and wait for every outstanding result
    task automatic wait_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0);
    endtask

    task automatic apb_access(logic is_write, logic [1:0] reg_sel, logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_AW'({reg_sel, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(logic [1:0] reg_sel);
        logic [APB_DW-1:0] readback;
        logic [APB_DW-1:0] want;
        case (reg_sel)
            REG_KEY_COUNT:    want = APB_DW'(key_count_cfg);
            REG_TABLE_LENGTH: want = APB_DW'(table_length_cfg);
            default:          want = APB_DW'(miss_value_cfg);
        endcase
        apb_access(1'b0, reg_sel, '0, readback);
        if (readback !== want) begin
            $error("register %0d readback: expected %0h, got %0h", reg_sel, want, readback);
            error_count++;
        end
    endtask

    // unused upper data bits carry noise
    task automatic set_register(logic [1:0] reg_sel, int value);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] field;
        logic [APB_DW-1:0] unused;
        case (reg_sel)
            REG_KEY_COUNT:    mask = APB_DW'((1 << KC_W) - 1);
            REG_TABLE_LENGTH: mask = APB_DW'((1 << LEN_W) - 1);
            default:          mask = APB_DW'((1 << VAL_W) - 1);
        endcase
        field = APB_DW'(value) & mask;
        apb_access(1'b1, reg_sel, (APB_DW'($urandom) & ~mask) | field, unused);
        case (reg_sel)
            REG_KEY_COUNT:    key_count_cfg    = field[KC_W-1:0];
            REG_TABLE_LENGTH: table_length_cfg = field[LEN_W-1:0];
            default:          miss_value_cfg   = field[VAL_W-1:0];
        endcase
        check_register(reg_sel);
    endtask

    // writes go in only once the core has gone quiet
    task automatic configure(int kc, int len, int miss);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        set_register(REG_KEY_COUNT, kc);
        set_register(REG_TABLE_LENGTH, len);
        set_register(REG_MISS_VALUE, miss);
        apb_release();
    endtask

    task automatic test_reset_defaults();
        check_register(REG_KEY_COUNT);
        check_register(REG_TABLE_LENGTH);
        check_register(REG_MISS_VALUE);
        apb_release();
        // empty table: every lookup misses
        send_lookup(16'h0000, 16'h0000, 16'h0000);
        send_lookup(16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_directed_lookups();
        send_write(8'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_write(8'd1, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001);
        send_write(8'd2, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h8000);
        send_write(8'd3, 16'h8000, 16'h0000, 16'h0001, 16'h1234);
        send_write(8'd4, 16'hFFFF, 16'h0000, 16'h0000, 16'h4321);
        send_write(8'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_write(8'd255, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        configure(3, 6, 16'hFFFF);
        send_lookup(16'h0000, 16'h0000, 16'h0000);
        send_lookup(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_lookup(16'h0001, 16'hFFFF, 16'hFFFF);
        send_lookup(16'h0001, 16'hFFFF, 16'hFFFE);
        send_lookup(16'hFFFF, 16'h0000, 16'h0001);
        configure(2, 6, 16'h0000);
        send_lookup(16'hFFFF, 16'h0000, 16'h1234);
        send_lookup(16'h8000, 16'h0001, 16'h0000);
        configure(1, 1, 16'hA5A5);
        send_lookup(16'h0000, 16'hFFFF, 16'hFFFF);
        send_lookup(16'h0001, 16'hFFFF, 16'h0000);
        // key count of zero compares one key
        configure(0, 6, 16'h5A5A);
        send_lookup(16'h8000, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_full_table();
        no_idle = 1'b1;
        load_table(TABLE_DEPTH, 1'b1);
        configure(3, TABLE_DEPTH, $urandom_range(16'hFFFF));
        send_lookup(table_model[0].key_a, table_model[0].key_b, table_model[0].key_c);
        send_lookup(table_model[TABLE_DEPTH-1].key_a, table_model[TABLE_DEPTH-1].key_b,
                    table_model[TABLE_DEPTH-1].key_c);
        repeat (20) send_random_lookup();
        no_idle = 1'b0;
        // lengths past the depth saturate
        configure(2, 2**LEN_W - 1, 16'h0000);
        repeat (8) send_random_lookup();
        configure(0, TABLE_DEPTH + 1, 16'hFFFF);
        repeat (8) send_random_lookup();
    endtask

    task automatic test_backpressure();
        configure(3, TABLE_DEPTH, $urandom_range(16'hFFFF));
        stall_request <= LONG_STALL;
        repeat (16) send_random_lookup();
        // hold off new requests until the backlog has drained
        wait_results();
    endtask

    task automatic test_random_rounds();
        int len;
        int round;
        round = 0;
        while (items_sent < ITEM_TARGET) begin
            no_idle = (round == 1);
            case ($urandom_range(9))
                0: len = 0;
                1: len = $urandom_range(TABLE_DEPTH + 1, 2**LEN_W - 1);
                2: len = $urandom_range(25, TABLE_DEPTH);
                default: begin
                    len = $urandom_range(1, 24);
                    load_table(len, $urandom_range(5) != 0);
                end
            endcase
            configure($urandom_range(3), len, $urandom_range(16'hFFFF));
            repeat ($urandom_range(12, 24)) begin
                if ($urandom_range(9) == 0) begin
                    send_write(FIELD_W'($urandom), KEY_WIDTH'($urandom), KEY_WIDTH'($urandom),
                               KEY_WIDTH'($urandom), VAL_W'($urandom));
                end else begin
                    send_random_lookup();
                end
            end
            round++;
        end
        no_idle = 1'b0;
    endtask

    // result side: check each accepted result, pick the next ready
    initial begin : result_sink
        int stall_left;
        t_lookup_result want;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("lookup result with none expected: found %0b value %0h index %0d",
                           rsp_ch.found, rsp_ch.result_value, rsp_ch.match_index);
                    error_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (rsp_ch.found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, rsp_ch.found);
                        error_count++;
                    end
                    if (rsp_ch.result_value !== want.result_value) begin
                        $error("result_value: expected %0h, got %0h", want.result_value,
                               rsp_ch.result_value);
                        error_count++;
                    end
                    if (rsp_ch.match_index !== want.match_index) begin
                        $error("match_index: expected %0d, got %0d", want.match_index,
                               rsp_ch.match_index);
                        error_count++;
                    end
                end
            end
            if (stall_request != 0) begin
                stall_left = stall_request;
                stall_request <= 0;
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_WRITE;
        req_ch.entry_index <= '0;
        req_ch.key_a       <= '0;
        req_ch.key_b       <= '0;
        req_ch.key_c       <= '0;
        req_ch.entry_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_lookups();
        test_full_table();
        test_backpressure();
        test_random_rounds();
        wait_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
